// ===== rtl/core/sset_pkg.sv =====
// ----------------------------------------------------------------------------
// sset_pkg
// Shared types, constants and the base time table of the exposure controller.
// ----------------------------------------------------------------------------
package sset_pkg;

  localparam int BASE_W = 6;
  localparam int STOP_W = 6;
  localparam int SECS_W = 19;
  localparam int ROM_W = 25;
  localparam int US_W = 57;
  localparam int PULSE_W = 20;

  localparam int TABLE_ENTRIES_DEF = 53;
  localparam int MAX_STOPS_DEF = 50;

  localparam logic [BASE_W-1:0] RESET_BASE = 6'd19;
  localparam logic [STOP_W-1:0] RESET_STOPS = 6'd10;
  localparam logic [SECS_W-1:0] INIT_SECONDS = 19'd10;
  localparam logic [SECS_W-1:0] CAP_SECONDS = 19'd359999;
  localparam logic [7:0] LABEL_MAX = 8'd52;
  localparam logic [US_W-1:0] ONE_SECOND_US = 57'd1000000;
  localparam logic [US_W-1:0] CAP_US = 57'd360000000000;
  localparam logic [3:0] CODE_UP = 4'b1011;
  localparam logic [3:0] CODE_DOWN = 4'b1000;

  // reciprocal constants for the divisions by constants
  localparam logic [26:0] RECIP_15625 = 27'd70368744;   // floor(2^40 / 15625)
  localparam logic [20:0] RECIP_3600 = 21'd1193047;     // ceil(2^32 / 3600)
  localparam logic [12:0] RECIP_60 = 13'd4370;          // ceil(2^18 / 60)

  typedef enum logic [2:0] {
    CMD_ENC    = 3'd0,
    CMD_MODE   = 3'd1,
    CMD_START  = 3'd2,
    CMD_CANCEL = 3'd3,
    CMD_TICK   = 3'd4,
    CMD_NOP    = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic pin_a;
    logic pin_b;
  } item_t;

  typedef struct packed {
    logic               shutter;
    logic [PULSE_W-1:0] pulse_us;
    logic [5:0]         label_index;
    logic               short_exposure;
    logic [BASE_W-1:0]  base_index;
    logic [STOP_W-1:0]  stop_count;
    logic               cursor_pos;
    logic               cursor_mode;
    logic               busy_res;
  } result_t;

  // what the back end hands to the time conversion pipeline
  typedef struct packed {
    result_t            res;
    logic               capt;
    logic [SECS_W-1:0]  remain;
    logic               key_init;
    logic [BASE_W-1:0]  key_base;
    logic [STOP_W-1:0]  key_stops;
    logic               wr;
  } carry_t;

  function automatic logic [ROM_W-1:0] rom_us(input logic [BASE_W-1:0] idx);
    logic [ROM_W-1:0] v;
    case (idx)
      6'd0:  v = 25'd125;      6'd1:  v = 25'd156;      6'd2:  v = 25'd200;
      6'd3:  v = 25'd250;      6'd4:  v = 25'd313;      6'd5:  v = 25'd400;
      6'd6:  v = 25'd500;      6'd7:  v = 25'd625;      6'd8:  v = 25'd800;
      6'd9:  v = 25'd1000;     6'd10: v = 25'd1250;     6'd11: v = 25'd1563;
      6'd12: v = 25'd2000;     6'd13: v = 25'd2500;     6'd14: v = 25'd3125;
      6'd15: v = 25'd4000;     6'd16: v = 25'd5000;     6'd17: v = 25'd6250;
      6'd18: v = 25'd8000;     6'd19: v = 25'd10000;    6'd20: v = 25'd12500;
      6'd21: v = 25'd16667;    6'd22: v = 25'd20000;    6'd23: v = 25'd25000;
      6'd24: v = 25'd33333;    6'd25: v = 25'd50000;    6'd26: v = 25'd66667;
      6'd27: v = 25'd76923;    6'd28: v = 25'd100000;   6'd29: v = 25'd125000;
      6'd30: v = 25'd166667;   6'd31: v = 25'd200000;   6'd32: v = 25'd250000;
      6'd33: v = 25'd333333;   6'd34: v = 25'd400000;   6'd35: v = 25'd500000;
      6'd36: v = 25'd625000;   6'd37: v = 25'd769231;   6'd38: v = 25'd1000000;
      6'd39: v = 25'd1300000;  6'd40: v = 25'd1600000;  6'd41: v = 25'd2000000;
      6'd42: v = 25'd2500000;  6'd43: v = 25'd3000000;  6'd44: v = 25'd4000000;
      6'd45: v = 25'd5000000;  6'd46: v = 25'd8000000;  6'd47: v = 25'd10000000;
      6'd48: v = 25'd13000000; 6'd49: v = 25'd15000000; 6'd50: v = 25'd20000000;
      6'd51: v = 25'd25000000;
      default: v = 25'd30000000;
    endcase
    return v;
  endfunction

  // exposure in microseconds, valid for stops below 32
  function automatic logic [US_W-1:0] exposure_us(input logic [BASE_W-1:0] idx,
                                                  input logic [STOP_W-1:0] stops);
    logic [US_W-1:0] base;
    base = {{(US_W-ROM_W){1'b0}}, rom_us(idx)};
    return base << stops[4:0];
  endfunction

endpackage

// ===== rtl/core/stop_scaled_exposure_timer_top.sv =====
// ----------------------------------------------------------------------------
// stop_scaled_exposure_timer_top
// Exposure controller with filter-stop scaling and a second countdown.
// ----------------------------------------------------------------------------
// One command word is taken per cycle while neither the queue nor the result
// side stalls, and gives exactly one result word. After it leaves the
// two-entry input queue a command passes one execute stage, then seven
// stages that turn the exposure into whole seconds and hours, minutes,
// seconds by reciprocal multiplies. A capture start that follows a
// long-exposure adjustment waits in the queue until that adjustment's set
// time leaves the third time stage; every other command flows at one per
// cycle unless the result side stalls.
module stop_scaled_exposure_timer_top import sset_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int MAX_STOPS = MAX_STOPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [2:0]         command,
  input  logic               pin_a,
  input  logic               pin_b,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               shutter,
  output logic [PULSE_W-1:0] pulse_us,
  output logic [6:0]         hours,
  output logic [5:0]         minutes,
  output logic [5:0]         seconds,
  output logic [5:0]         label_index,
  output logic               short_exposure,
  output logic [BASE_W-1:0]  base_index,
  output logic [STOP_W-1:0]  stop_count,
  output logic               cursor_pos,
  output logic               cursor_mode,
  output logic               busy_res
);

  logic              q_valid;
  item_t             q_item;
  logic              q_pop;
  logic              adv;
  logic              wb_valid;
  logic [SECS_W-1:0] wb_secs;
  logic              e_valid;
  carry_t            e_carry;
  result_t           res;

  sset_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .command   (command),
    .pin_a     (pin_a),
    .pin_b     (pin_b),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  sset_exec #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_STOPS     (MAX_STOPS)
  ) u_exec (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .adv      (adv),
    .wb_valid (wb_valid),
    .wb_secs  (wb_secs),
    .e_valid  (e_valid),
    .e_carry  (e_carry)
  );

  sset_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .e_valid   (e_valid),
    .e_carry   (e_carry),
    .adv       (adv),
    .wb_valid  (wb_valid),
    .wb_secs   (wb_secs),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .hours     (hours),
    .minutes   (minutes),
    .seconds   (seconds)
  );

  assign shutter = res.shutter;
  assign pulse_us = res.pulse_us;
  assign label_index = res.label_index;
  assign short_exposure = res.short_exposure;
  assign base_index = res.base_index;
  assign stop_count = res.stop_count;
  assign cursor_pos = res.cursor_pos;
  assign cursor_mode = res.cursor_mode;
  assign busy_res = res.busy_res;

endmodule

// ===== rtl/core/sset_front.sv =====
// ----------------------------------------------------------------------------
// sset_front
// Accepts command words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module sset_front import sset_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [2:0] command,
  input  logic       pin_a,
  input  logic       pin_b,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      cls;

  always_comb begin
    cls.pin_a = pin_a;
    cls.pin_b = pin_b;
    unique case (command)
      3'd0:    cls.cmd = CMD_ENC;
      3'd1:    cls.cmd = CMD_MODE;
      3'd2:    cls.cmd = CMD_START;
      3'd3:    cls.cmd = CMD_CANCEL;
      3'd4:    cls.cmd = CMD_TICK;
      default: cls.cmd = CMD_NOP;
    endcase
  end

  assign cmd_stall = (count == 2'd2);
  assign push = cmd_valid && !cmd_stall;
  assign q_valid = (count != 2'd0);
  assign q_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== rtl/core/sset_exec.sv =====
// ----------------------------------------------------------------------------
// sset_exec
// Back end: carries out one command a cycle on the controller state, unless held or stalled.
// ----------------------------------------------------------------------------
module sset_exec import sset_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int MAX_STOPS = MAX_STOPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  input  logic              adv,
  input  logic              wb_valid,
  input  logic [SECS_W-1:0] wb_secs,
  output logic              e_valid,
  output carry_t            e_carry
);

  logic [BASE_W-1:0] base_idx, base_next;
  logic [STOP_W-1:0] stops_reg, stops_next;
  logic              cursor_reg, cursor_next;
  logic              mode_reg, mode_next;
  logic [1:0]        last_pins, last_pins_next;
  logic              capturing, capturing_next;
  logic              short_flag, short_next;
  logic [SECS_W-1:0] remain, remain_next;
  logic [SECS_W-1:0] set_secs;
  logic              key_init, key_init_next;
  logic [BASE_W-1:0] key_base, key_base_next;
  logic [STOP_W-1:0] key_stops, key_stops_next;
  logic [3:0]        pending;
  logic              hold;
  logic              issue;
  logic              wr;
  logic              turn;
  logic              up;
  logic [3:0]        code;
  logic [US_W-1:0]   us;
  logic              is_short;
  logic [PULSE_W-1:0] pulse;
  logic [7:0]        label_sum;
  carry_t            c;

  // a capture start needs the set time of the last long exposure
  assign hold = (q_item.cmd == CMD_START) && !capturing && !short_flag && (pending != 4'd0);
  assign issue = q_valid && adv && !hold;
  assign q_pop = issue;

  always_comb begin
    base_next = base_idx;
    stops_next = stops_reg;
    cursor_next = cursor_reg;
    mode_next = mode_reg;
    last_pins_next = last_pins;
    capturing_next = capturing;
    remain_next = remain;
    turn = 1'b0;
    up = 1'b0;
    code = {last_pins, q_item.pin_a, q_item.pin_b};
    case (q_item.cmd)
      CMD_ENC: begin
        if (!capturing) begin
          last_pins_next = {q_item.pin_a, q_item.pin_b};
          if (code == CODE_UP || code == CODE_DOWN) begin
            up = (code == CODE_UP);
            if (mode_reg) begin
              cursor_next = up;
            end else begin
              turn = 1'b1;
              if (cursor_reg) begin
                if (up && stops_reg < STOP_W'(MAX_STOPS)) begin
                  stops_next = stops_reg + 1'b1;
                end else if (!up && stops_reg != '0) begin
                  stops_next = stops_reg - 1'b1;
                end
              end else begin
                if (up && base_idx != '0) begin
                  base_next = base_idx - 1'b1;
                end else if (!up && base_idx < BASE_W'(TABLE_ENTRIES - 1)) begin
                  base_next = base_idx + 1'b1;
                end
              end
            end
          end
        end
      end
      CMD_MODE: begin
        if (!capturing) begin
          mode_next = !mode_reg;
        end
      end
      CMD_START: begin
        if (!capturing && !short_flag && set_secs != '0) begin
          remain_next = set_secs;
          capturing_next = 1'b1;
        end
      end
      CMD_CANCEL: begin
        if (capturing) begin
          capturing_next = 1'b0;
        end
      end
      CMD_TICK: begin
        if (capturing) begin
          remain_next = remain - 1'b1;
          if (remain_next == '0) begin
            capturing_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // one table read serves both the recompute and the short pulse
  always_comb begin
    us = exposure_us(base_next, stops_next);
    is_short = (stops_next < STOP_W'(32)) && (us < ONE_SECOND_US);
    short_next = turn ? is_short : short_flag;
    wr = turn && !is_short;
    key_init_next = wr ? 1'b0 : key_init;
    key_base_next = wr ? base_next : key_base;
    key_stops_next = wr ? stops_next : key_stops;
    pulse = '0;
    if (q_item.cmd == CMD_START && !capturing && short_flag) begin
      pulse = us[PULSE_W-1:0];
    end
    label_sum = 8'(base_next) + 8'(stops_next) * 8'd3;
    if (label_sum > LABEL_MAX) begin
      label_sum = LABEL_MAX;
    end
  end

  always_comb begin
    c.res.shutter = capturing_next;
    c.res.pulse_us = pulse;
    c.res.label_index = short_next ? label_sum[5:0] : 6'd0;
    c.res.short_exposure = short_next;
    c.res.base_index = base_next;
    c.res.stop_count = stops_next;
    c.res.cursor_pos = cursor_next;
    c.res.cursor_mode = mode_next;
    c.res.busy_res = capturing_next;
    c.capt = capturing_next;
    c.remain = remain_next;
    c.key_init = key_init_next;
    c.key_base = key_base_next;
    c.key_stops = key_stops_next;
    c.wr = wr;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      e_carry <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_idx <= RESET_BASE;
      stops_reg <= RESET_STOPS;
      cursor_reg <= 1'b0;
      mode_reg <= 1'b0;
      last_pins <= 2'b00;
      capturing <= 1'b0;
      short_flag <= 1'b0;
      remain <= '0;
      set_secs <= INIT_SECONDS;
      key_init <= 1'b1;
      key_base <= '0;
      key_stops <= '0;
      pending <= 4'd0;
      e_valid <= 1'b0;
    end else begin
      if (adv) begin
        e_valid <= issue;
      end
      if (issue) begin
        base_idx <= base_next;
        stops_reg <= stops_next;
        cursor_reg <= cursor_next;
        mode_reg <= mode_next;
        last_pins <= last_pins_next;
        capturing <= capturing_next;
        short_flag <= short_next;
        remain <= remain_next;
        key_init <= key_init_next;
        key_base <= key_base_next;
        key_stops <= key_stops_next;
      end
      if (wb_valid) begin
        set_secs <= wb_secs;
      end
      pending <= pending + 4'(issue && wr) - 4'(wb_valid);
    end
  end

endmodule

// ===== rtl/core/sset_conv.sv =====
// ----------------------------------------------------------------------------
// sset_conv
// Time pipeline: exposure to whole seconds, then hours, minutes, seconds.
// ----------------------------------------------------------------------------
module sset_conv import sset_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              e_valid,
  input  carry_t            e_carry,
  output logic              adv,
  output logic              wb_valid,
  output logic [SECS_W-1:0] wb_secs,
  output logic              res_valid,
  input  logic              res_stall,
  output result_t           res,
  output logic [6:0]        hours,
  output logic [5:0]        minutes,
  output logic [5:0]        seconds
);

  logic [6:0]        v;
  carry_t            c1, c2, c3, c4, c5, c6, c7;
  logic [32:0]       x1, x2;
  logic              cap1, cap2;
  logic [19:0]       q2;
  logic [SECS_W-1:0] secs3, secs3_q, secs4;
  logic [6:0]        h4, h5, h6, h7;
  logic [11:0]       rem5, rem6;
  logic [5:0]        m6, m7, s7;
  logic [US_W-1:0]   us;
  logic [59:0]       prod;
  logic [33:0]       r3;
  logic [19:0]       q3;
  logic [SECS_W-1:0] secs_sel;
  logic [39:0]       hprod;
  logic [18:0]       hsub;
  logic [23:0]       mprod;
  logic [11:0]       msub;

  assign adv = !(v[6] && res_stall);

  always_comb begin
    us = exposure_us(e_carry.key_base, e_carry.key_stops);
    prod = 60'(x1) * 60'(RECIP_15625);
    r3 = {1'b0, x2} - 34'(q2) * 34'd15625;
    q3 = (r3 >= 34'd15625) ? q2 + 1'b1 : q2;
    if (c2.key_init) begin
      secs3 = INIT_SECONDS;
    end else if (cap2) begin
      secs3 = CAP_SECONDS;
    end else begin
      secs3 = q3[SECS_W-1:0];
    end
    // remaining time while capturing, else the set time just converted
    secs_sel = c3.capt ? c3.remain : secs3_q;
    hprod = 40'(secs_sel) * 40'(RECIP_3600);
    hsub = secs4 - 19'(h4) * 19'd3600;
    mprod = 24'(rem5) * 24'(RECIP_60);
    msub = rem6 - 12'(m6) * 12'd60;
  end

  assign wb_valid = adv && v[2] && c3.wr;
  assign wb_secs = secs3_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      // exposure scaled down by 64, rest of the divide by 15625 follows
      c1 <= e_carry;
      x1 <= us[38:6];
      cap1 <= (e_carry.key_stops >= STOP_W'(32)) || (us >= CAP_US);
      c2 <= c1;
      x2 <= x1;
      cap2 <= cap1;
      q2 <= prod[59:40];
      c3 <= c2;
      secs3_q <= secs3;
      c4 <= c3;
      secs4 <= secs_sel;
      h4 <= hprod[38:32];
      c5 <= c4;
      h5 <= h4;
      rem5 <= hsub[11:0];
      c6 <= c5;
      h6 <= h5;
      rem6 <= rem5;
      m6 <= mprod[23:18];
      c7 <= c6;
      h7 <= h6;
      m7 <= m6;
      s7 <= msub[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[5:0], e_valid};
    end
  end

  assign res_valid = v[6];
  assign res = c7.res;
  assign hours = h7;
  assign minutes = m7;
  assign seconds = s7;

endmodule

// ===== rtl/core/sset_checker.sv =====
// ----------------------------------------------------------------------------
// sset_checker
// Port-level checks of the exposure controller, bound to the top level.
// ----------------------------------------------------------------------------
module sset_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic       shutter,
  input logic [19:0] pulse_us,
  input logic [6:0] hours,
  input logic [5:0] minutes,
  input logic [5:0] seconds,
  input logic [5:0] label_index,
  input logic       short_exposure,
  input logic       busy_res
);

  // shutter line follows the countdown state
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (shutter == busy_res))
    else $error("shutter and busy disagree");

  // a quick pulse only comes from a short exposure while idle
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && pulse_us != 20'd0) |-> (short_exposure && !busy_res))
    else $error("pulse without short exposure");

  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !short_exposure) |-> (label_index == 6'd0))
    else $error("label on long exposure");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (hours <= 7'd99 && minutes <= 6'd59 && seconds <= 6'd59))
    else $error("time out of range");

  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> res_valid)
    else $error("result dropped while stalled");

endmodule

bind stop_scaled_exposure_timer_top sset_checker u_sset_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res_valid),
  .res_stall      (res_stall),
  .shutter        (shutter),
  .pulse_us       (pulse_us),
  .hours          (hours),
  .minutes        (minutes),
  .seconds        (seconds),
  .label_index    (label_index),
  .short_exposure (short_exposure),
  .busy_res       (busy_res)
);

// ===== dv/tb_stop_scaled_exposure_timer_top.sv =====
// ----------------------------------------------------------------------------
// tb_stop_scaled_exposure_timer_top
// Drives command words into the exposure controller, predicts every result
// word and compares it field by field, with random idling and backpressure.
// ----------------------------------------------------------------------------
module tb_stop_scaled_exposure_timer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sset_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1200;

  typedef struct packed {
    logic        shutter;
    logic [19:0] pulse_us;
    logic [6:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [5:0]  label_index;
    logic        short_exposure;
    logic [5:0]  base_index;
    logic [5:0]  stop_count;
    logic        cursor_pos;
    logic        cursor_mode;
    logic        busy_res;
  } exp_word_t;

  typedef struct {
    logic [2:0] cmd;
    logic       a;
    logic       b;
    logic       typed;
    exp_word_t  word;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  logic [2:0] command = '0;
  logic pin_a = 1'b0;
  logic pin_b = 1'b0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic shutter, short_exposure, cursor_pos, cursor_mode, busy_res;
  logic [19:0] pulse_us;
  logic [6:0] hours;
  logic [5:0] minutes, seconds, label_index, base_index, stop_count;

  stop_scaled_exposure_timer_top i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  int unsigned p_base, p_stops, p_cursor, p_mode, p_pins, p_capt, p_shut, p_short;
  int unsigned p_set[3], p_rem[3];
  exp_word_t expected_words[$];
  int errors = 0;
  bit stim_done = 0;
  bit calm = 0;
  bit hold_long = 0;

  const int unsigned base_rom[53] = '{
    125, 156, 200, 250, 313, 400, 500, 625, 800, 1000,
    1250, 1563, 2000, 2500, 3125, 4000, 5000, 6250, 8000, 10000,
    12500, 16667, 20000, 25000, 33333, 50000, 66667, 76923,
    100000, 125000, 166667, 200000, 250000, 333333, 400000,
    500000, 625000, 769231, 1000000, 1300000, 1600000, 2000000,
    2500000, 3000000, 4000000, 5000000, 8000000, 10000000,
    13000000, 15000000, 20000000, 25000000, 30000000};

  function automatic longint unsigned exposure_of();
    return longint'(base_rom[p_base > 52 ? 52 : p_base]) << p_stops;
  endfunction

  function automatic void recompute_time();
    longint unsigned us, secs;
    us = exposure_of();
    if (p_stops < 32 && us < 1000000) begin
      p_short = 1;
      return;
    end
    p_short = 0;
    secs = (p_stops >= 32) ? 359999 : us / 1000000;
    if (secs > 359999) secs = 359999;
    p_set[0] = 32'(secs / 3600);
    secs = secs % 3600;
    p_set[1] = 32'(secs / 60);
    p_set[2] = 32'(secs % 60);
  endfunction

  function automatic void apply_turn(bit up);
    if (p_mode) begin
      p_cursor = 32'(up);
      return;
    end
    if (p_cursor) begin
      if (up) begin
        if (p_stops < 50) p_stops++;
      end else if (p_stops > 0) p_stops--;
    end else begin
      if (up) begin
        if (p_base > 0) p_base--;
      end else if (p_base < 52) p_base++;
    end
    recompute_time();
  endfunction

  function automatic exp_word_t predict_word(logic [2:0] c, logic a, logic b);
    exp_word_t w;
    int unsigned pins, code, label;
    longint unsigned us;
    w = '0;
    if (c == CMD_ENC && !p_capt) begin
      pins = 32'({a, b});
      code = ((p_pins & 3) << 2) | pins;
      if (code == CODE_UP) apply_turn(1);
      else if (code == CODE_DOWN) apply_turn(0);
      p_pins = pins;
    end else if (c == CMD_MODE && !p_capt) begin
      p_mode ^= 1;
    end else if (c == CMD_START && !p_capt) begin
      if (p_short) begin
        us = exposure_of();
        if (p_stops < 32 && us < 1000000) w.pulse_us = 20'(us);
      end else if (p_set[0] | p_set[1] | p_set[2]) begin
        p_rem = p_set;
        p_capt = 1;
        p_shut = 1;
      end
    end else if (c == CMD_CANCEL && p_capt) begin
      p_capt = 0;
      p_shut = 0;
    end else if (c == CMD_TICK && p_capt) begin
      if (p_rem[2] > 0) p_rem[2]--;
      else if (p_rem[1] > 0) begin
        p_rem[1]--;
        p_rem[2] = 59;
      end else if (p_rem[0] > 0) begin
        p_rem[0]--;
        p_rem[1] = 59;
        p_rem[2] = 59;
      end
      if ((p_rem[0] | p_rem[1] | p_rem[2]) == 0) begin
        p_capt = 0;
        p_shut = 0;
      end
    end
    label = 0;
    if (p_short) begin
      label = p_base + 3 * p_stops;
      if (label > 52) label = 52;
    end
    w.shutter = p_shut[0];
    w.hours = 7'(p_capt ? p_rem[0] : p_set[0]);
    w.minutes = 6'(p_capt ? p_rem[1] : p_set[1]);
    w.seconds = 6'(p_capt ? p_rem[2] : p_set[2]);
    w.label_index = 6'(label);
    w.short_exposure = p_short[0];
    w.base_index = 6'(p_base);
    w.stop_count = 6'(p_stops);
    w.cursor_pos = p_cursor[0];
    w.cursor_mode = p_mode[0];
    w.busy_res = p_capt[0];
    return w;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // sends one word, holding it until accepted
  task automatic send_word(logic [2:0] c, logic a, logic b, bit typed, exp_word_t tw);
    exp_word_t w;
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    command <= c;
    pin_a <= a;
    pin_b <= b;
    w = predict_word(c, a, b);
    // typed rows are checked against the typed word, and the predictor too
    if (typed && w != tw) report_mismatch("directed row predictor", 1, 0);
    expected_words.push_back(typed ? tw : w);
    do @(posedge clk); while (cmd_stall);
  endtask

  // one encoder detent: 00 -> 10 -> 11 is an up-turn, 11 -> 10 -> 00 down
  task automatic turn_detent(bit up);
    exp_word_t z;
    z = '0;
    if (up) begin
      send_word(CMD_ENC, 0, 0, 0, z);
      send_word(CMD_ENC, 1, 0, 0, z);
      send_word(CMD_ENC, 1, 1, 0, z);
    end else begin
      send_word(CMD_ENC, 1, 0, 0, z);
      send_word(CMD_ENC, 0, 0, 0, z);
    end
  endtask

  // result side
  always @(posedge clk) begin
    exp_word_t got, want;
    if (!rst && res_valid && !res_stall) begin
      got = '{shutter, pulse_us, hours, minutes, seconds, label_index,
              short_exposure, base_index, stop_count, cursor_pos, cursor_mode, busy_res};
      if (expected_words.size() == 0) report_mismatch("unexpected word", 1, 0);
      else begin
        want = expected_words.pop_front();
        if (got.shutter != want.shutter) report_mismatch("shutter", got.shutter, want.shutter);
        if (got.pulse_us != want.pulse_us)
          report_mismatch("pulse_us", got.pulse_us, want.pulse_us);
        if (got.hours != want.hours) report_mismatch("hours", got.hours, want.hours);
        if (got.minutes != want.minutes) report_mismatch("minutes", got.minutes, want.minutes);
        if (got.seconds != want.seconds) report_mismatch("seconds", got.seconds, want.seconds);
        if (got.label_index != want.label_index)
          report_mismatch("label_index", got.label_index, want.label_index);
        if (got.short_exposure != want.short_exposure)
          report_mismatch("short_exposure", got.short_exposure, want.short_exposure);
        if (got.base_index != want.base_index)
          report_mismatch("base_index", got.base_index, want.base_index);
        if (got.stop_count != want.stop_count)
          report_mismatch("stop_count", got.stop_count, want.stop_count);
        if (got.cursor_pos != want.cursor_pos)
          report_mismatch("cursor_pos", got.cursor_pos, want.cursor_pos);
        if (got.cursor_mode != want.cursor_mode)
          report_mismatch("cursor_mode", got.cursor_mode, want.cursor_mode);
        if (got.busy_res != want.busy_res)
          report_mismatch("busy_res", got.busy_res, want.busy_res);
      end
    end
  end

  // receiver stalls in bursts, plus one long hold-off
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        res_stall <= 1'b1;
        repeat (60) @(posedge clk);
        res_stall <= 1'b0;
        hold_long = 0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 6);
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no handshake
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    exp_word_t rw;
    int k, sel;
    bit up_dir;
    p_base = 19; p_stops = 10; p_cursor = 0; p_mode = 0; p_pins = 0;
    p_capt = 0; p_shut = 0; p_short = 0;
    p_set = '{0, 0, 10};
    p_rem = '{0, 0, 0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // after reset: idle tick, idle cancel, unused codes; state unchanged
    rw = '0;
    rw.seconds = 10; rw.base_index = 19; rw.stop_count = 10;
    rows.push_back('{CMD_TICK, 0, 0, 1, rw});
    rows.push_back('{CMD_CANCEL, 1, 1, 1, rw});
    rows.push_back('{3'd5, 1, 0, 1, rw});
    rows.push_back('{3'd7, 0, 1, 1, rw});
    rows.push_back('{3'd6, 1, 1, 1, rw});
    // non-turn codes only move last pins
    rows.push_back('{CMD_ENC, 0, 1, 1, rw});
    rows.push_back('{CMD_ENC, 0, 0, 1, rw});
    // 00->10 gives 0b0010: nothing, 10->11 gives up-turn on base
    rows.push_back('{CMD_ENC, 1, 0, 0, rw});
    rows.push_back('{CMD_ENC, 1, 1, 0, rw});
    // start a long exposure, then mode toggles and cursor turns sent while capturing
    rows.push_back('{CMD_START, 0, 0, 0, rw});
    rows.push_back('{CMD_MODE, 0, 0, 0, rw});
    rows.push_back('{CMD_ENC, 1, 0, 0, rw});
    rows.push_back('{CMD_ENC, 1, 1, 0, rw});
    rows.push_back('{CMD_ENC, 1, 0, 0, rw});
    rows.push_back('{CMD_ENC, 1, 1, 0, rw});
    rows.push_back('{CMD_MODE, 0, 0, 0, rw});
    rows.push_back('{CMD_START, 0, 0, 0, rw});
    rows.push_back('{CMD_TICK, 0, 0, 0, rw});
    rows.push_back('{CMD_ENC, 0, 0, 0, rw});
    rows.push_back('{CMD_MODE, 0, 0, 0, rw});
    rows.push_back('{CMD_START, 0, 0, 0, rw});
    rows.push_back('{CMD_CANCEL, 0, 0, 0, rw});
    foreach (rows[i]) send_word(rows[i].cmd, rows[i].a, rows[i].b, rows[i].typed,
                                rows[i].word);

    // drive the values to their limits: stops to max and zero, base both ends
    rw = '0;
    send_word(CMD_MODE, 0, 0, 0, rw);
    send_word(CMD_ENC, 0, 0, 0, rw);
    turn_detent(1);
    send_word(CMD_MODE, 0, 0, 0, rw);
    for (k = 0; k < 60; k++) turn_detent(1);
    for (k = 0; k < 60; k++) turn_detent(0);
    send_word(CMD_MODE, 0, 0, 0, rw);
    send_word(CMD_ENC, 0, 0, 0, rw);
    turn_detent(0);
    send_word(CMD_MODE, 0, 0, 0, rw);
    for (k = 0; k < 60; k++) turn_detent(1);
    for (k = 0; k < 60; k++) turn_detent(0);
    send_word(CMD_START, 0, 0, 0, rw);
    send_word(CMD_CANCEL, 0, 0, 0, rw);

    // fill the block while the receiver holds off
    hold_long = 1;
    for (k = 0; k < 20; k++) send_word(CMD_NOP, k[0], k[1], 0, rw);

    k = 0;
    while (k < N_RANDOM) begin
      if (k > N_RANDOM - 150) calm = 1;
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        up_dir = 1'($urandom_range(0, 1));
        turn_detent(up_dir);
        k += up_dir ? 3 : 2;
      end else if (sel < 48) begin
        send_word(CMD_MODE, 1'($urandom), 1'($urandom), 0, rw);
        k++;
      end else if (sel < 60) begin
        send_word(CMD_START, 1'($urandom), 1'($urandom), 0, rw);
        k++;
      end else if (sel < 64) begin
        send_word(CMD_CANCEL, 1'($urandom), 1'($urandom), 0, rw);
        k++;
      end else if (sel < 85) begin
        send_word(CMD_TICK, 1'($urandom), 1'($urandom), 0, rw);
        k++;
      end else begin
        send_word(3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom), 0, rw);
        k++;
      end
    end
    cmd_valid <= 1'b0;
    stim_done = 1;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
